// ===== sv/edpq_pkg.sv =====
// shared types and constants of the error-diffused predictive quantizer
package edpq_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CNT_W     = COL_W + 1;
    localparam int CH        = 4;
    localparam int PIX_W     = 8;
    localparam int ERR_W     = 9;
    localparam int TAG_W     = 16;
    localparam int SUM_W     = 16;
    localparam int D_W       = 10;
    localparam int T_W       = 12;
    localparam int TMAG_W    = 10;
    localparam int DIV_CNT_W = $clog2(TMAG_W);

    typedef enum logic [2:0] {
        REG_WIDTH,
        REG_HEIGHT,
        REG_STEP,
        REG_BIAS,
        REG_ROUND,
        REG_MAXDEV,
        REG_CLAMP
    } cfg_idx_t;

    typedef logic signed [ERR_W-1:0] err_t;

    // per-column history: last output pixel, newest error with its row, the error before it
    typedef struct packed {
        logic [CH-1:0][PIX_W-1:0] pix;
        logic [CH-1:0][ERR_W-1:0] e0;
        logic [TAG_W-1:0]         tag0;
        logic [CH-1:0][ERR_W-1:0] e1;
    } hist_t;

    typedef struct packed {
        logic sum;
        logic start;
        logic step;
    } lane_ctl_t;

    typedef struct packed {
        err_t             c_m1;
        err_t             c_m2;
        err_t             p_m2;
        err_t             p_m1;
        err_t             p_0;
        err_t             p_p1;
        err_t             p_p2;
        err_t             o_m1;
        err_t             o_0;
        err_t             o_p1;
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] left;
    } lane_win_t;

    typedef struct packed {
        logic [7:0]        step;
        logic signed [8:0] h;
        logic [9:0]        rnd;
        logic [9:0]        maxdev;
        logic [7:0]        clamp;
        logic              clamp_en;
    } lane_cfg_t;

endpackage

// ===== sv/edpq_ram.sv =====
// generic simple dual-port ram with registered read
module edpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/edpq_lane.sv =====
// one channel lane: diffusion sum, predictor, iterative modulo and final selection
module edpq_lane (
    input  logic                        aclk,
    input  edpq_pkg::lane_ctl_t         ctl,
    input  edpq_pkg::lane_win_t         win,
    input  edpq_pkg::lane_cfg_t         cfg,
    input  logic [edpq_pkg::PIX_W-1:0]  pix_in,
    output logic [edpq_pkg::PIX_W-1:0]  pix_out,
    output edpq_pkg::err_t              err_out
);
    import edpq_pkg::*;

    function automatic logic signed [SUM_W-1:0] sx(input err_t e);
        return SUM_W'(e);
    endfunction

    logic signed [SUM_W-1:0] dsum, dbias;
    logic [SUM_W-1:0]        dmag, dq;
    logic signed [D_W-1:0]   d_calc;
    logic [PIX_W-1:0]        a_calc;

    logic signed [D_W-1:0]   d_reg;
    logic [PIX_W-1:0]        a_reg, v_reg;
    logic signed [T_W-1:0]   t_reg;
    logic                    neg_reg;
    logic [TMAG_W-1:0]       mag_reg;
    logic [7:0]              rem_reg;

    logic signed [T_W-1:0]   t_calc, t_abs, r_s, q0, q1, a_s, hi, lo, e_s;
    logic [8:0]              trial;
    logic [7:0]              rem_next;
    logic signed [T_W:0]     dev, mdv;
    logic                    bad, pass;

    always_comb begin
        dsum = 16'sd5 * sx(win.c_m1) + 16'sd3 * sx(win.c_m2)
             + 16'sd2 * sx(win.p_m2) + 16'sd4 * sx(win.p_m1) + 16'sd5 * sx(win.p_0)
             + 16'sd4 * sx(win.p_p1) + 16'sd2 * sx(win.p_p2)
             + 16'sd2 * sx(win.o_m1) + 16'sd3 * sx(win.o_0) + 16'sd2 * sx(win.o_p1);
        // rounding term takes the sign of the sum, then divide by 32 toward zero
        if (dsum < 0) begin
            dbias = dsum - $signed({{(SUM_W-10){1'b0}}, cfg.rnd});
        end else begin
            dbias = dsum + $signed({{(SUM_W-10){1'b0}}, cfg.rnd});
        end
        dmag = dbias[SUM_W-1] ? SUM_W'(-dbias) : SUM_W'(dbias);
        dq   = dmag >> 5;
        d_calc = dbias[SUM_W-1] ? -$signed(D_W'(dq)) : $signed(D_W'(dq));
        a_calc = PIX_W'(({1'b0, win.above} + {1'b0, win.left}) >> 1);
    end

    always_comb begin
        t_calc = $signed({4'b0, v_reg}) + T_W'(d_reg) + T_W'(cfg.h)
               - $signed({4'b0, a_reg});
        t_abs  = (t_calc < 0) ? -t_calc : t_calc;
        trial  = {rem_reg, mag_reg[TMAG_W-1]};
        rem_next = (trial >= {1'b0, cfg.step}) ? 8'(trial - {1'b0, cfg.step}) : trial[7:0];
    end

    always_ff @(posedge aclk) begin
        if (ctl.sum) begin
            d_reg <= d_calc;
            a_reg <= a_calc;
            v_reg <= pix_in;
        end
        if (ctl.start) begin
            t_reg   <= t_calc;
            neg_reg <= t_calc < 0;
            mag_reg <= t_abs[TMAG_W-1:0];
            rem_reg <= '0;
        end
        if (ctl.step) begin
            rem_reg <= rem_next;
            mag_reg <= {mag_reg[TMAG_W-2:0], 1'b0};
        end
    end

    always_comb begin
        // remainder carries the sign of t, as a truncating modulo does
        r_s  = neg_reg ? -$signed({4'b0, rem_reg}) : $signed({4'b0, rem_reg});
        a_s  = $signed({4'b0, a_reg});
        q0   = t_reg - r_s + a_s;
        hi   = a_s + $signed({4'b0, cfg.clamp});
        lo   = a_s - $signed({4'b0, cfg.clamp});
        q1   = q0;
        if (cfg.clamp_en) begin
            if (q0 > hi) begin
                q1 = hi;
            end else if (q0 < lo) begin
                q1 = lo;
            end
        end
        dev  = (T_W+1)'(q1) - $signed({5'b0, v_reg});
        mdv  = $signed({3'b0, cfg.maxdev});
        bad  = (q1 < 0) || (q1 > 12'sd255) || (dev > mdv) || (-dev > mdv);
        pass = (v_reg == '0) || (v_reg == '1);
        e_s  = $signed({4'b0, v_reg}) - q1;
        if (pass || bad) begin
            pix_out = v_reg;
            err_out = '0;
        end else begin
            pix_out = q1[PIX_W-1:0];
            err_out = ERR_W'(e_s);
        end
    end

endmodule

// ===== sv/error_diffused_predictive_quantizer.sv =====
// top level of the error-diffused predictive quantizer
// Quantizes RGBA pixels in raster order against the average of the output pixels above and
// to the left, with three-row Sierra error diffusion; four channel lanes work side by side
// and their results are merged into one output register. For each item the column history
// memory is read at the accepting edge, then come the diffusion-sum state, the setup state,
// the bit-serial modulo in each lane and the final state, which waits while the output
// register holds a stalled result; the input side takes no new item until the return to
// idle. Each row end adds the states that reload the history of columns 0 and 1. After reset
// and at every frame end a clearing pass writes all 4096 history entries, one per cycle,
// during which no item is accepted. A finished result waits in the output register while the
// next item is taken in.
module error_diffused_predictive_quantizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red_in, green_in, blue_in, alpha_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // red_out, green_out, blue_out, alpha_out
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import edpq_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SUM, ST_START, ST_DIV, ST_FIN,
        ST_ROWEND, ST_PRE0, ST_PRE1, ST_PRE2
    } state_t;

    typedef logic [CH-1:0][ERR_W-1:0] errv_t;
    typedef logic [CH-1:0][PIX_W-1:0] pixv_t;

    state_t state_reg;
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    logic [7:0]  step_reg;
    logic [8:0]  bias_reg;
    logic [9:0]  round_reg, maxdev_reg;
    logic [7:0]  clamp_reg;

    logic [CNT_W-1:0]     col_reg;
    logic [TAG_W-1:0]     row_reg;
    logic [COL_W-1:0]     clr_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    pixv_t                pix_in_reg;
    logic                 rd_ok_reg;
    errv_t pm2_reg, pm1_reg, p0_reg, pp1_reg, om1_reg, o0_reg, op1_reg, cm1_reg, cm2_reg;
    errv_t nxtp_reg, nxto_reg;
    pixv_t a0_reg, ap1_reg, nxta_reg, left_reg;
    logic        m_valid_reg;
    logic [31:0] m_data_reg;

    logic [12:0] w_eff;
    logic [15:0] h_eff;
    logic [7:0]  step_eff;
    logic        x2_ok, x2_in, fin_go, last_col, last_row;
    lane_ctl_t   lctl;
    lane_cfg_t   lcfg;
    errv_t       prev_rd, older_rd, lane_err;
    pixv_t       pix_rd, lane_pix;

    logic             ram_we, ram_re;
    logic [COL_W-1:0] ram_waddr, ram_raddr;
    hist_t            ram_wdata, rd_q;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = 13'd1;
        end else if (width_reg > 13'(MAX_WIDTH)) begin
            w_eff = 13'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        h_eff    = (height_reg == '0) ? 16'd1 : height_reg;
        step_eff = (step_reg == '0) ? 8'd1 : step_reg;
        x2_ok    = ({1'b0, col_reg} + 14'd2) < {1'b0, w_eff};
        x2_in    = ({1'b0, col_reg} + 14'd2) < 14'(MAX_WIDTH);
        last_col = ({1'b0, col_reg} + 14'd1) >= {1'b0, w_eff};
        last_row = ({1'b0, row_reg} + 17'd1) >= {1'b0, h_eff};
        fin_go   = !m_valid_reg || m_tready;
        s_tready = (state_reg == ST_IDLE) && (col_reg < w_eff);
    end

    // history read-back: older row is the newest entry written two or more rows ago
    always_comb begin
        for (int i = 0; i < CH; i++) begin
            prev_rd[i]  = rd_ok_reg ? rd_q.e0[i] : '0;
            older_rd[i] = !rd_ok_reg ? '0 :
                          (rd_q.tag0 == row_reg - 16'd1) ? rd_q.e1[i] : rd_q.e0[i];
            pix_rd[i]   = rd_ok_reg ? rd_q.pix[i] : '0;
        end
    end

    always_comb begin
        lctl.sum   = state_reg == ST_SUM;
        lctl.start = state_reg == ST_START;
        lctl.step  = state_reg == ST_DIV;
        lcfg.step  = step_eff;
        lcfg.h     = (bias_reg != '0) ? $signed(bias_reg) : $signed({1'b0, step_eff >> 1});
        lcfg.rnd   = round_reg;
        lcfg.maxdev = maxdev_reg;
        lcfg.clamp = clamp_reg;
        lcfg.clamp_en = (clamp_reg != '0) && (col_reg != '0) && (row_reg != '0);
    end

    for (genvar i = 0; i < CH; i++) begin : g_lane
        lane_win_t win;
        always_comb begin
            // columns at or past the current width count as zero
            win.c_m1  = cm1_reg[i];
            win.c_m2  = cm2_reg[i];
            win.p_m2  = pm2_reg[i];
            win.p_m1  = pm1_reg[i];
            win.p_0   = p0_reg[i];
            win.p_p1  = last_col ? '0 : pp1_reg[i];
            win.p_p2  = x2_ok ? prev_rd[i] : '0;
            win.o_m1  = om1_reg[i];
            win.o_0   = o0_reg[i];
            win.o_p1  = last_col ? '0 : op1_reg[i];
            win.above = a0_reg[i];
            win.left  = left_reg[i];
        end
        edpq_lane u_lane (
            .aclk    (aclk),
            .ctl     (lctl),
            .win     (win),
            .cfg     (lcfg),
            .pix_in  (pix_in_reg[i]),
            .pix_out (lane_pix[i]),
            .err_out (lane_err[i])
        );
    end

    always_comb begin
        ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_FIN && fin_go);
        ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : col_reg[COL_W-1:0];
        ram_wdata = '0;
        if (state_reg == ST_FIN) begin
            ram_wdata.pix  = lane_pix;
            ram_wdata.e0   = lane_err;
            ram_wdata.tag0 = row_reg;
            ram_wdata.e1   = p0_reg;
        end
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (state_reg)
            ST_IDLE: begin
                ram_re    = s_tready && s_tvalid && x2_in;
                ram_raddr = COL_W'(col_reg + CNT_W'(2));
            end
            ST_PRE0: begin
                ram_re = 1'b1;
            end
            ST_PRE1: begin
                ram_re    = 1'b1;
                ram_raddr = COL_W'(1);
            end
            default: begin
            end
        endcase
    end

    edpq_ram #(
        .WIDTH ($bits(hist_t)),
        .DEPTH (MAX_WIDTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            div_cnt_reg <= '0;
            rd_ok_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            width_reg   <= 13'd1024;
            height_reg  <= 16'd1024;
            step_reg    <= 8'd6;
            bias_reg    <= '0;
            round_reg   <= 10'd16;
            maxdev_reg  <= 10'd512;
            clamp_reg   <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_addr))
                    REG_WIDTH:  width_reg  <= cfg_wdata[12:0];
                    REG_HEIGHT: height_reg <= cfg_wdata;
                    REG_STEP:   step_reg   <= cfg_wdata[7:0];
                    REG_BIAS:   bias_reg   <= cfg_wdata[8:0];
                    REG_ROUND:  round_reg  <= cfg_wdata[9:0];
                    REG_MAXDEV: maxdev_reg <= cfg_wdata[9:0];
                    REG_CLAMP:  clamp_reg  <= cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
            if (m_valid_reg && m_tready && !(state_reg == ST_FIN && fin_go)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    pm2_reg <= '0; pm1_reg <= '0; p0_reg <= '0; pp1_reg <= '0;
                    om1_reg <= '0; o0_reg <= '0; op1_reg <= '0;
                    cm1_reg <= '0; cm2_reg <= '0;
                    a0_reg <= '0; ap1_reg <= '0; left_reg <= '0;
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == COL_W'(MAX_WIDTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (col_reg >= w_eff) begin
                        state_reg <= ST_ROWEND;
                    end else if (s_tvalid) begin
                        pix_in_reg <= s_tdata;
                        rd_ok_reg  <= x2_in;
                        state_reg  <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    nxtp_reg  <= prev_rd;
                    nxto_reg  <= older_rd;
                    nxta_reg  <= pix_rd;
                    state_reg <= ST_START;
                end
                ST_START: begin
                    div_cnt_reg <= '0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV: begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIV_CNT_W'(TMAG_W - 1)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (fin_go) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= lane_pix;
                        // slide the column window by one
                        pm2_reg <= pm1_reg; pm1_reg <= p0_reg; p0_reg <= pp1_reg;
                        pp1_reg <= nxtp_reg;
                        om1_reg <= o0_reg; o0_reg <= op1_reg; op1_reg <= nxto_reg;
                        a0_reg  <= ap1_reg; ap1_reg <= nxta_reg;
                        cm2_reg <= cm1_reg; cm1_reg <= lane_err;
                        left_reg <= lane_pix;
                        col_reg <= col_reg + 1'b1;
                        state_reg <= last_col ? ST_ROWEND : ST_IDLE;
                    end
                end
                ST_ROWEND: begin
                    col_reg  <= '0;
                    pm2_reg  <= '0; pm1_reg <= '0; om1_reg <= '0;
                    cm1_reg  <= '0; cm2_reg <= '0; left_reg <= '0;
                    if (last_row) begin
                        row_reg   <= '0;
                        clr_reg   <= '0;
                        state_reg <= ST_CLEAR;
                    end else begin
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= ST_PRE0;
                    end
                end
                ST_PRE0: begin
                    rd_ok_reg <= 1'b1;
                    state_reg <= ST_PRE1;
                end
                ST_PRE1: begin
                    p0_reg    <= prev_rd;
                    o0_reg    <= older_rd;
                    a0_reg    <= pix_rd;
                    rd_ok_reg <= 1'b1;
                    state_reg <= ST_PRE2;
                end
                ST_PRE2: begin
                    pp1_reg   <= prev_rd;
                    op1_reg   <= older_rd;
                    ap1_reg   <= pix_rd;
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== sv/edpq_check.sv =====
// port-level checks of the quantizer, bound to the top level
module edpq_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("item taken while another is in work");

    // a new result only appears after the input side has been busy
    a_result_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared with no item in work");

    // reset empties both sides
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("handshake active after reset");

endmodule

bind error_diffused_predictive_quantizer edpq_check u_edpq_check (.*);

// ===== dv/edpq_checker.sv =====
// checker for the error-diffused predictive quantizer: predicts each result and compares
module edpq_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);
    import edpq_pkg::*;

    logic [12:0]       width_r;
    logic [15:0]       height_r;
    logic [7:0]        step_r;
    logic signed [8:0] bias_r;
    logic [9:0]        round_r;
    logic [9:0]        maxdev_r;
    logic [7:0]        clamp_r;

    int   err_cur  [MAX_WIDTH][CH];
    int   err_prev [MAX_WIDTH][CH];
    int   err_old  [MAX_WIDTH][CH];
    int   pix_above[MAX_WIDTH][CH];
    int   pix_left [CH];
    int   col;
    int   row;

    logic [31:0] expected_pixels[$];

    assign pending = expected_pixels.size();

    function automatic int used_width();
        if (width_r < 1) return 1;
        if (width_r > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_r);
    endfunction

    // 0: current row, 1: previous row, 2: older row; outside the row reads as zero
    function automatic int err_rd(int which, int p, int c, int w);
        if (p < 0 || p >= w) return 0;
        case (which)
            0: return err_cur[p][c];
            1: return err_prev[p][c];
            default: return err_old[p][c];
        endcase
    endfunction

    function automatic void clear_history();
        for (int i = 0; i < MAX_WIDTH; i++) begin
            for (int c = 0; c < CH; c++) begin
                err_cur[i][c] = 0;
                err_prev[i][c] = 0;
                err_old[i][c] = 0;
                pix_above[i][c] = 0;
            end
        end
        for (int c = 0; c < CH; c++) pix_left[c] = 0;
        col = 0;
        row = 0;
    endfunction

    function automatic void finish_row();
        int hh;
        hh = (height_r != 0) ? int'(height_r) : 1;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            for (int c = 0; c < CH; c++) begin
                err_old[i][c] = err_prev[i][c];
                err_prev[i][c] = err_cur[i][c];
            end
        end
        for (int c = 0; c < CH; c++) pix_left[c] = 0;
        col = 0;
        if (row + 1 >= hh) clear_history();
        else row = (row + 1) & 16'hFFFF;
    endfunction

    function automatic logic [31:0] quantize_pixel(logic [31:0] pix);
        int w, x, stp, hb, orig, v, d, a, t;
        logic [31:0] res;
        w = used_width();
        if (col >= w) finish_row();
        x = col;
        stp = (step_r != 0) ? int'(step_r) : 1;
        hb = (bias_r != 0) ? int'(bias_r) : (stp >> 1);
        for (int c = 0; c < CH; c++) begin
            orig = int'(pix[8*c +: 8]);
            v = orig;
            if (v > 0 && v < 255) begin
                d = 5 * err_rd(0, x - 1, c, w) + 3 * err_rd(0, x - 2, c, w)
                  + 2 * err_rd(1, x - 2, c, w) + 4 * err_rd(1, x - 1, c, w)
                  + 5 * err_rd(1, x, c, w) + 4 * err_rd(1, x + 1, c, w)
                  + 2 * err_rd(1, x + 2, c, w)
                  + 2 * err_rd(2, x - 1, c, w) + 3 * err_rd(2, x, c, w)
                  + 2 * err_rd(2, x + 1, c, w);
                d += (d < 0) ? -int'(round_r) : int'(round_r);
                d = d / 32;
                a = (pix_above[x][c] + pix_left[c]) / 2;
                t = v + d + hb - a;
                v = (t - (t % stp)) + a;
                if (clamp_r != 0 && x != 0 && row != 0) begin
                    if (v > a + int'(clamp_r)) v = a + int'(clamp_r);
                    else if (v < a - int'(clamp_r)) v = a - int'(clamp_r);
                end
                if (v < 0 || v > 255 || v - orig > int'(maxdev_r) || orig - v > int'(maxdev_r))
                    v = orig;
                err_cur[x][c] = orig - v;
            end else begin
                err_cur[x][c] = 0;
            end
            res[8*c +: 8] = v[7:0];
        end
        for (int c = 0; c < CH; c++) begin
            pix_above[x][c] = int'(res[8*c +: 8]);
            pix_left[c] = int'(res[8*c +: 8]);
        end
        col++;
        if (col >= w) finish_row();
        return res;
    endfunction

    always @(posedge aclk) begin
        logic [31:0] exp_pix;
        int          nbad;
        if (!aresetn) begin
            width_r    <= 13'd1024;
            height_r   <= 16'd1024;
            step_r     <= 8'd6;
            bias_r     <= '0;
            round_r    <= 10'd16;
            maxdev_r   <= 10'd512;
            clamp_r    <= '0;
            fail_count <= 0;
            clear_history();
            expected_pixels.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %h", $time, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_pix = expected_pixels.pop_front();
                    nbad = 0;
                    for (int c = 0; c < CH; c++) begin
                        if (m_tdata[8*c +: 8] !== exp_pix[8*c +: 8]) begin
                            $display("%0t: channel %0d mismatch, expected %h, actual %h",
                                     $time, c, exp_pix[8*c +: 8], m_tdata[8*c +: 8]);
                            nbad++;
                        end
                    end
                    if (nbad != 0) fail_count <= fail_count + nbad;
                end
            end
            if (s_tvalid && s_tready)
                expected_pixels.push_back(quantize_pixel(s_tdata));
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_addr))
                    REG_WIDTH:  width_r  <= cfg_wdata[12:0];
                    REG_HEIGHT: height_r <= cfg_wdata[15:0];
                    REG_STEP:   step_r   <= cfg_wdata[7:0];
                    REG_BIAS:   bias_r   <= cfg_wdata[8:0];
                    REG_ROUND:  round_r  <= cfg_wdata[9:0];
                    REG_MAXDEV: maxdev_r <= cfg_wdata[9:0];
                    REG_CLAMP:  clamp_r  <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== dv/tb_error_diffused_predictive_quantizer.sv =====
// testbench top: stimulus, configuration phases and verdict for the quantizer
module tb_error_diffused_predictive_quantizer;
    import edpq_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // red_in, green_in, blue_in, alpha_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // red_out, green_out, blue_out, alpha_out
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    int          fail_count;
    int          pending;
    bit          quiet = 1'b0;

    error_diffused_predictive_quantizer i_dut (.*);

    edpq_checker i_checker (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #400_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side stalls in bursts
    initial begin
        int n;
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 9);
                m_tready <= 1'b0;
            end else begin
                n = $urandom_range(1, 12);
                m_tready <= 1'b1;
            end
            repeat (n) @(negedge aclk);
        end
    end

    task automatic cfg_write(cfg_idx_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
    endtask

    task automatic drain_and_wait();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        // covers a frame-end clearing pass plus the pipeline
        repeat (4200) @(negedge aclk);
    endtask

    task automatic set_config(int w, int h, int stp, int bias, int rnd, int md, int cl);
        cfg_write(REG_WIDTH, w[15:0]);
        cfg_write(REG_HEIGHT, h[15:0]);
        cfg_write(REG_STEP, stp[15:0]);
        cfg_write(REG_BIAS, bias[15:0] & 16'h01FF);
        cfg_write(REG_ROUND, rnd[15:0]);
        cfg_write(REG_MAXDEV, md[15:0]);
        cfg_write(REG_CLAMP, cl[15:0]);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(logic [31:0] pix);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9) - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            3: return 8'd254;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int pick(int a, int b, int c, int lo, int hi);
        case ($urandom_range(0, 3))
            0: return a;
            1: return b;
            2: return c;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    logic [31:0] directed[24] = '{
        32'h00000000, 32'hFFFFFFFF, 32'h01FE7F80, 32'hFE01807F,
        32'h55AA55AA, 32'hAA55AA55, 32'h10203040, 32'hF0E0D0C0,
        32'h00FF01FE, 32'h7F7F7F7F, 32'h80808080, 32'h01010101,
        32'hFEFEFEFE, 32'h0F0F0F0F, 32'hF0F0F0F0, 32'h33CC33CC,
        32'h12345678, 32'h9ABCDEF0, 32'h00000001, 32'hFF000080,
        32'h02030405, 32'hFDFCFBFA, 32'h40404040, 32'hC0C0C0C0
    };

    initial begin
        int w, h, n;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (4200) @(negedge aclk);

        set_config(4, 3, 6, 0, 16, 512, 0);
        foreach (directed[i]) send_pixel(directed[i]);
        drain_and_wait();

        for (int ph = 0; ph < 12; ph++) begin
            w = pick(1, 2, 3, 1, 9);
            h = pick(1, 2, 4, 1, 4);
            n = 48;
            if (ph == 2) begin
                w = 4096; h = 65535; n = 24;
            end else if (ph == 5) begin
                w = 0; h = 0;
            end else if (ph == 8) begin
                w = 8191; h = 2; n = 20;
            end
            if (ph == 11) quiet = 1'b1;
            set_config(w, h, pick(1, 255, 0, 1, 40), pick(0, -255, 255, -30, 30),
                       pick(0, 1023, 16, 0, 1023), pick(0, 1023, 512, 0, 300),
                       pick(0, 255, 0, 1, 20));
            for (int i = 0; i < n; i++)
                send_pixel({rand_channel(), rand_channel(), rand_channel(), rand_channel()});
            drain_and_wait();
        end

        repeat (50) @(negedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/edpq_pkg.sv
sv/edpq_ram.sv
sv/edpq_lane.sv
sv/error_diffused_predictive_quantizer.sv
sv/edpq_check.sv
dv/edpq_checker.sv
dv/tb_error_diffused_predictive_quantizer.sv
